>>> rtl/pdma_pkg.sv
// Package for the projected density matrix accumulator.
// Holds the opcode, register index and sequencer state types and the multiplier result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pdma_pkg;

    typedef enum logic [2:0] {
        OP_LOAD_COEF   = 3'd0,
        OP_LOAD_MATRIX = 3'd1,
        OP_WRITE_ACC   = 3'd2,
        OP_RUN         = 3'd3,
        OP_READ_ACC    = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        REG_NUM_PROJECTORS = 2'd0,
        REG_NUM_LOCAL      = 2'd1,
        REG_NUM_TOTAL      = 2'd2
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MUL,
        ST_WAIT,
        ST_DONE
    } t_state;

    // Result of the shared multiplier: a one-cycle valid, the rounded product and
    // an overflow flag.
    typedef struct packed {
        logic               valid;
        logic               sat;
        logic signed [63:0] prod;
    } t_mul_out;

endpackage
`default_nettype wire

>>> rtl/pdma_mul.sv
// Multi-cycle signed 64 x 32 multiplier with Q24 rounding and saturation.
// Splits the product into two 32 x 32 passes. Depends on pdma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pdma_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [31:0] i_b,
    output pdma_pkg::t_mul_out      o_out
);
    import pdma_pkg::*;

    logic [4:0]         r_vld;
    logic               r_neg;
    logic [63:0]        r_ua;
    logic [31:0]        r_ub;
    logic [63:0]        r_plo;
    logic [63:0]        r_phi;
    logic [95:0]        r_sum;
    logic signed [63:0] r_prod;
    logic               r_sat;

    logic [63:0] ua;
    logic [31:0] ub;
    logic [63:0] q;
    logic [63:0] limit;
    logic        ovf;
    logic [63:0] mag;

    always_comb begin
        ua    = i_a[63] ? (~i_a + 64'd1) : i_a;
        ub    = i_b[31] ? (~i_b + 32'd1) : i_b;
        q     = r_sum[87:24];
        limit = r_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        ovf   = (|r_sum[95:88]) || (q > limit);
        mag   = ovf ? limit : q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_a[63] ^ i_b[31];
            r_ua  <= ua;
            r_ub  <= ub;
        end
        if (r_vld[0]) begin
            r_plo <= 64'(r_ua[31:0]) * 64'(r_ub);
        end
        if (r_vld[1]) begin
            r_phi <= 64'(r_ua[63:32]) * 64'(r_ub);
        end
        if (r_vld[2]) begin
            r_sum <= {r_phi, 32'd0} + 96'(r_plo) + 96'h80_0000;
        end
        if (r_vld[3]) begin
            r_sat  <= ovf;
            r_prod <= r_neg ? (~mag + 64'd1) : mag;
        end
    end

    assign o_out.valid = r_vld[4];
    assign o_out.sat   = r_sat;
    assign o_out.prod  = r_prod;

endmodule
`default_nettype wire

>>> rtl/projected_density_matrix_accumulate.sv
// A load or accumulator write takes effect at acceptance and gives no result; a read gives its
// result strobe in the cycle after acceptance. Reads and loads may come every cycle while no run
// holds busy. Each multiply-accumulate step of a run waits on the shared 64 x 32 multiplier, which
// makes two 32 x 32 passes, before the next step begins. Reset is synchronous and active low and
// clears the control state and the flag; the projector count register resets to one and the other
// count registers to zero. The stores are undefined until written. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module projected_density_matrix_accumulate #(
    parameter int MAX_ORBITALS   = 64,
    parameter int MAX_PROJECTORS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_opcode,
    input  wire logic [5:0]         i_row,
    input  wire logic [5:0]         i_col,
    input  wire logic signed [31:0] i_sample_value,
    input  wire logic signed [63:0] i_acc_value,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [6:0]         i_cfg_wdata,
    output logic                    o_result_valid,
    output logic signed [63:0]      o_result_value,
    output logic                    o_saturated,
    output logic                    o_is_done
);
    import pdma_pkg::*;

    // Index and count widths for each dimension, and the depth and index width of each flattened store.
    localparam int OW   = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
    localparam int PW   = (MAX_PROJECTORS > 1) ? $clog2(MAX_PROJECTORS) : 1;
    localparam int OCW  = $clog2(MAX_ORBITALS + 1);
    localparam int PCW  = $clog2(MAX_PROJECTORS + 1);
    localparam int CD   = MAX_ORBITALS * MAX_PROJECTORS;
    localparam int MD   = MAX_ORBITALS * MAX_ORBITALS;
    localparam int AD   = MAX_PROJECTORS * MAX_PROJECTORS;
    localparam int CAW  = (CD > 1) ? $clog2(CD) : 1;
    localparam int MAW  = (MD > 1) ? $clog2(MD) : 1;
    localparam int AAW  = (AD > 1) ? $clog2(AD) : 1;

    // Configuration registers.
    logic [4:0] r_cfg_np;
    logic [6:0] r_cfg_loc;
    logic [6:0] r_cfg_tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_np  <= 5'd1;
            r_cfg_loc <= '0;
            r_cfg_tot <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_index'(i_cfg_addr))
                REG_NUM_PROJECTORS: r_cfg_np  <= i_cfg_wdata[4:0];
                REG_NUM_LOCAL:      r_cfg_loc <= i_cfg_wdata;
                REG_NUM_TOTAL:      r_cfg_tot <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer registers. The run walks an inner phase that builds the partial vector for
    // one local orbital and an outer phase that folds it into the accumulator block.
    t_state         r_state, n_state;
    logic           r_outer, n_outer;
    logic [OW-1:0]  r_i1, n_i1;
    logic [OW-1:0]  r_i2, n_i2;
    logic [PW-1:0]  r_p1, n_p1;
    logic [PW-1:0]  r_p2, n_p2;
    logic [PCW-1:0] r_nh, n_nh;
    logic [OCW-1:0] r_tot, n_tot;
    logic [OCW-1:0] r_loc, n_loc;
    logic           r_sat, n_sat;
    logic           r_res_valid, n_res_valid;
    logic           r_res_done, n_res_done;
    logic           r_res_zero, n_res_zero;

    logic           accept;
    t_opcode        op;
    logic           orb_row_ok;
    logic           orb_col_ok;
    logic           prj_row_ok;
    logic           prj_col_ok;
    logic [OCW-1:0] tot_clamped;
    logic           last_p2;
    logic           last_p1;
    logic           last_i2;
    logic           last_i1;

    // Memories and their registered read data.
    logic signed [31:0] coef_mem [CD];
    logic signed [31:0] mat_mem  [MD];
    logic signed [63:0] acc_mem  [AD];
    logic signed [63:0] part_mem [MAX_PROJECTORS];
    logic signed [31:0] r_coef_rd;
    logic signed [31:0] r_mat_rd;
    logic signed [63:0] r_acc_rd;
    logic signed [63:0] r_part_rd;

    logic           issue;
    logic           acc_rd_en;
    logic [AAW-1:0] acc_rd_addr;
    logic           acc_wr_en;
    logic [AAW-1:0] acc_wr_addr;
    logic [63:0]    acc_wr_data;
    logic [CAW-1:0] coef_rd_addr;
    logic [MAW-1:0] mat_rd_addr;
    logic [AAW-1:0] host_acc_addr;
    logic [AAW-1:0] run_acc_addr;

    t_mul_out           mul_out;
    logic signed [63:0] mul_a;
    logic               wb;
    logic signed [63:0] add_a;
    logic signed [63:0] add_s;
    logic               add_ovf;
    logic signed [63:0] add_res;

    assign accept = start && !busy;
    assign op     = t_opcode'(i_opcode);
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        orb_row_ok  = 32'(i_row) < MAX_ORBITALS;
        orb_col_ok  = 32'(i_col) < MAX_ORBITALS;
        prj_row_ok  = 32'(i_row) < MAX_PROJECTORS;
        prj_col_ok  = 32'(i_col) < MAX_PROJECTORS;
        tot_clamped = (32'(r_cfg_tot) > MAX_ORBITALS) ? OCW'(MAX_ORBITALS) : OCW'(r_cfg_tot);
        last_p2     = r_p2 == PW'(r_nh - PCW'(1));
        last_p1     = r_p1 == PW'(r_nh - PCW'(1));
        last_i2     = r_i2 == OW'(r_tot - OCW'(1));
        last_i1     = r_i1 == OW'(r_loc - OCW'(1));
    end

    // Address generation. The inner phase reads K[i2][p2] and X[i1][i2]; the outer phase
    // reads K[i1][p1] and A[p1][p2]. Both read the partial vector at p2.
    always_comb begin
        issue         = (r_state == ST_ISSUE);
        coef_rd_addr  = r_outer ? CAW'(CAW'(r_i1) * CAW'(MAX_PROJECTORS)) + CAW'(r_p1)
                                : CAW'(CAW'(r_i2) * CAW'(MAX_PROJECTORS)) + CAW'(r_p2);
        mat_rd_addr   = MAW'(MAW'(r_i1) * MAW'(MAX_ORBITALS)) + MAW'(r_i2);
        run_acc_addr  = AAW'(AAW'(r_p1) * AAW'(MAX_PROJECTORS)) + AAW'(r_p2);
        host_acc_addr = AAW'(AAW'(PW'(i_row)) * AAW'(MAX_PROJECTORS)) + AAW'(PW'(i_col));
        acc_rd_en     = (issue && r_outer)
                        || (accept && op == OP_READ_ACC && prj_row_ok && prj_col_ok);
        acc_rd_addr   = busy ? run_acc_addr : host_acc_addr;
    end

    always_ff @(posedge i_clk) begin
        if (accept && op == OP_LOAD_COEF && orb_row_ok && prj_col_ok) begin
            coef_mem[CAW'(CAW'(OW'(i_row)) * CAW'(MAX_PROJECTORS)) + CAW'(PW'(i_col))]
                <= i_sample_value;
        end
        if (issue) begin
            r_coef_rd <= coef_mem[coef_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && op == OP_LOAD_MATRIX && orb_row_ok && orb_col_ok) begin
            mat_mem[MAW'(MAW'(OW'(i_row)) * MAW'(MAX_ORBITALS)) + MAW'(OW'(i_col))]
                <= i_sample_value;
        end
        if (issue && !r_outer) begin
            r_mat_rd <= mat_mem[mat_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_wr_en) begin
            acc_mem[acc_wr_addr] <= acc_wr_data;
        end
        if (acc_rd_en) begin
            r_acc_rd <= acc_mem[acc_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb && !r_outer) begin
            part_mem[r_p2] <= add_res;
        end
        if (issue) begin
            r_part_rd <= part_mem[r_p2];
        end
    end

    // The shared multiplier always takes a coefficient as its narrow operand.
    assign mul_a = r_outer ? r_part_rd : 64'(r_mat_rd);

    pdma_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_MUL),
        .i_a     (mul_a),
        .i_b     (r_coef_rd),
        .o_out   (mul_out)
    );

    // Saturating accumulate. The first inner term of each orbital starts the partial sum
    // from zero, which stands in for clearing the partial vector.
    always_comb begin
        wb      = (r_state == ST_WAIT) && mul_out.valid;
        add_a   = r_outer ? r_acc_rd : ((r_i2 == '0) ? 64'sd0 : r_part_rd);
        add_s   = add_a + mul_out.prod;
        add_ovf = (add_a[63] == mul_out.prod[63]) && (add_s[63] != add_a[63]);
        add_res = add_ovf ? (add_a[63] ? 64'sh8000_0000_0000_0000
                                       : 64'sh7FFF_FFFF_FFFF_FFFF) : add_s;
    end

    always_comb begin
        acc_wr_en   = (wb && r_outer) || (accept && op == OP_WRITE_ACC && prj_row_ok && prj_col_ok);
        acc_wr_addr = busy ? run_acc_addr : host_acc_addr;
        acc_wr_data = busy ? add_res : i_acc_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_outer     <= 1'b0;
            r_i1        <= '0;
            r_i2        <= '0;
            r_p1        <= '0;
            r_p2        <= '0;
            r_nh        <= '0;
            r_tot       <= '0;
            r_loc       <= '0;
            r_sat       <= 1'b0;
            r_res_valid <= 1'b0;
            r_res_done  <= 1'b0;
            r_res_zero  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_outer     <= n_outer;
            r_i1        <= n_i1;
            r_i2        <= n_i2;
            r_p1        <= n_p1;
            r_p2        <= n_p2;
            r_nh        <= n_nh;
            r_tot       <= n_tot;
            r_loc       <= n_loc;
            r_sat       <= n_sat;
            r_res_valid <= n_res_valid;
            r_res_done  <= n_res_done;
            r_res_zero  <= n_res_zero;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_outer     = r_outer;
        n_i1        = r_i1;
        n_i2        = r_i2;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_nh        = r_nh;
        n_tot       = r_tot;
        n_loc       = r_loc;
        n_sat       = r_sat;
        n_res_valid = 1'b0;
        n_res_done  = 1'b0;
        n_res_zero  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && op == OP_READ_ACC) begin
                    // An out-of-range read answers zero.
                    n_res_valid = 1'b1;
                    n_res_zero  = !(prj_row_ok && prj_col_ok);
                end else if (accept && op == OP_RUN) begin
                    n_nh    = (32'(r_cfg_np) > MAX_PROJECTORS) ? PCW'(MAX_PROJECTORS)
                                                               : PCW'(r_cfg_np);
                    n_tot   = tot_clamped;
                    n_loc   = (OCW'(r_cfg_loc) > tot_clamped || 32'(r_cfg_loc) > MAX_ORBITALS)
                              ? tot_clamped : OCW'(r_cfg_loc);
                    n_sat   = 1'b0;
                    n_outer = 1'b0;
                    n_i1    = '0;
                    n_i2    = '0;
                    n_p1    = '0;
                    n_p2    = '0;
                    // No local orbitals or no projectors means there is nothing to do.
                    n_state = (n_nh == '0 || n_loc == '0) ? ST_DONE : ST_ISSUE;
                end
            end
            ST_ISSUE: n_state = ST_MUL;
            ST_MUL:   n_state = ST_WAIT;
            ST_WAIT: begin
                if (mul_out.valid) begin
                    n_sat   = r_sat | mul_out.sat | add_ovf;
                    n_state = ST_ISSUE;
                    n_p2    = last_p2 ? '0 : r_p2 + PW'(1);
                    if (last_p2) begin
                        if (!r_outer) begin
                            n_i2 = last_i2 ? '0 : r_i2 + OW'(1);
                            if (last_i2) begin
                                n_outer = 1'b1;
                                n_p1    = '0;
                            end
                        end else begin
                            n_p1 = last_p1 ? '0 : r_p1 + PW'(1);
                            if (last_p1) begin
                                n_outer = 1'b0;
                                n_i1    = r_i1 + OW'(1);
                                if (last_i1) begin
                                    n_state = ST_DONE;
                                end
                            end
                        end
                    end
                end
            end
            ST_DONE: begin
                n_state     = ST_IDLE;
                n_res_valid = 1'b1;
                n_res_done  = 1'b1;
                n_res_zero  = 1'b1;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_result_value = r_res_zero ? 64'sd0 : r_acc_rd;
    assign o_saturated    = r_sat;
    assign o_is_done      = r_res_done;

    // A multiplier result only ever arrives while the sequencer waits for it.
    a_mul_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_out.valid |-> r_state == ST_WAIT)
        else $error("multiplier result outside the wait state");

    // A run clears the saturation flag as it begins.
    a_run_clears_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_saturated)
        else $error("saturation flag not cleared at run start");

    // The done state always produces exactly the done result next.
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |=> o_result_valid && o_is_done && !busy)
        else $error("run completion not reported");

    // Outside a run the multiplier stays quiet.
    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !mul_out.valid)
        else $error("multiplier active while idle");

endmodule
`default_nettype wire
